FILE: rtl/cnms_pkg.sv
// Shared types, constants and small functions for the 3-D non-maximum suppression block.
// Used by every module under rtl except cnms_store; depends on nothing.
package cnms_pkg;

  localparam int DEF_MAX_X       = 256;
  localparam int DEF_MAX_Y       = 256;
  localparam int DEF_SAMPLE_BITS = 16;
  localparam int NUM_DIRS        = 13;
  localparam int DIR_IDX_W       = 4;

  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_SIZE_X    = 3'd0;
  localparam cfg_idx_t CFG_SIZE_Y    = 3'd1;
  localparam cfg_idx_t CFG_SIZE_Z    = 3'd2;
  localparam cfg_idx_t CFG_THRESHOLD = 3'd3;
  localparam cfg_idx_t CFG_INV_X     = 3'd4;
  localparam cfg_idx_t CFG_INV_Y     = 3'd5;
  localparam cfg_idx_t CFG_INV_Z     = 3'd6;

  typedef logic [DIR_IDX_W-1:0] dir_idx_t;
  typedef logic signed [1:0] dcomp_t;

  typedef struct packed {
    dcomp_t dx;
    dcomp_t dy;
    dcomp_t dz;
  } dir_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_GRAD, ST_SEARCH, ST_NB0, ST_NB1, ST_NB2, ST_OUT
  } seq_state_t;

  typedef enum logic [2:0] {
    DS_IDLE, DS_DOT, DS_SQ0, DS_SQ1, DS_SQ2, DS_CMP
  } ds_phase_t;

  typedef struct packed {
    logic     done;
    dir_idx_t best;
  } ds_status_t;

  localparam dcomp_t DP = 2'sb01;
  localparam dcomp_t DZ = 2'sb00;
  localparam dcomp_t DN = 2'sb11;

  function automatic dir_t dir_vec(input dir_idx_t i);
    dir_t d;
    case (i)
      4'd0:    d = '{DZ, DZ, DP};
      4'd1:    d = '{DZ, DP, DZ};
      4'd2:    d = '{DP, DZ, DZ};
      4'd3:    d = '{DP, DP, DZ};
      4'd4:    d = '{DP, DN, DZ};
      4'd5:    d = '{DP, DN, DN};
      4'd6:    d = '{DP, DP, DN};
      4'd7:    d = '{DP, DN, DP};
      4'd8:    d = '{DP, DP, DP};
      4'd9:    d = '{DZ, DP, DP};
      4'd10:   d = '{DZ, DP, DN};
      4'd11:   d = '{DP, DZ, DN};
      4'd12:   d = '{DP, DZ, DP};
      default: d = '{DZ, DZ, DZ};
    endcase
    return d;
  endfunction

  function automatic logic [1:0] dir_k(input dir_t d);
    return {1'b0, d.dx != DZ} + {1'b0, d.dy != DZ} + {1'b0, d.dz != DZ};
  endfunction

  function automatic logic [1:0] mod3(input logic [2:0] v);
    logic [2:0] r;
    r = (v >= 3'd3) ? v - 3'd3 : v;
    return r[1:0];
  endfunction

endpackage

FILE: rtl/cnms_store.sv
// Plane store: single-port synchronous memory holding the three most recent planes.
// Uses no package items; instantiated by the top level.
module cnms_store #(
  parameter int AW = 18,
  parameter int DEPTH = 196608,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic          re,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/cnms_dirsel.sv
// Direction search unit: walks the 13 lattice directions with one shared squarer.
// Depends on cnms_pkg; instantiated by the top level.
module cnms_dirsel
  import cnms_pkg::*;
#(
  parameter int GW = 34
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [GW-1:0] gx,
  input  logic signed [GW-1:0] gy,
  input  logic signed [GW-1:0] gz,
  output ds_status_t           status
);

  localparam int DTW = GW + 2;
  localparam int DW  = DTW;
  localparam int LW  = (DW + 1) / 2;
  localparam int SQW = 2 * DW;
  localparam int PW  = SQW + 2;
  localparam int SHW = $clog2(2 * LW + 1);

  ds_phase_t phase_r, phase_nxt;
  dir_idx_t  idx_r, best_r;
  logic [DW-1:0]  d_r;
  logic [SQW-1:0] acc_r, bsq_r;
  logic [1:0]     bk_r;
  logic           done_r;

  dir_t               dir;
  logic [1:0]         k;
  logic signed [DTW-1:0] dot;
  logic [DW-1:0]      absd;
  logic [LW-1:0]      mul_a, mul_b;
  logic [2*LW-1:0]    prod;
  logic [SHW-1:0]     sh;
  logic [SQW-1:0]     acc_nxt;
  logic [PW-1:0]      lhs, rhs;
  logic               take;

  function automatic logic signed [DTW-1:0] term(input dcomp_t c,
                                                 input logic signed [GW-1:0] g);
    logic signed [DTW-1:0] ge;
    ge = DTW'(g);
    case (c)
      DP:      return ge;
      DN:      return -ge;
      default: return '0;
    endcase
  endfunction

  function automatic logic [PW-1:0] kmul(input logic [SQW-1:0] v, input logic [1:0] kk);
    logic [PW-1:0] ve;
    ve = PW'(v);
    case (kk)
      2'd1:    return ve;
      2'd2:    return ve << 1;
      2'd3:    return ve + (ve << 1);
      default: return '0;
    endcase
  endfunction

  always_comb begin
    dir  = dir_vec(idx_r);
    k    = dir_k(dir);
    dot  = term(dir.dx, gx) + term(dir.dy, gy) + term(dir.dz, gz);
    absd = dot[DTW-1] ? DW'(-dot) : DW'(dot);
  end

  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      DS_IDLE: if (start) phase_nxt = DS_DOT;
      DS_DOT:  phase_nxt = DS_SQ0;
      DS_SQ0:  phase_nxt = DS_SQ1;
      DS_SQ1:  phase_nxt = DS_SQ2;
      DS_SQ2:  phase_nxt = DS_CMP;
      DS_CMP:  phase_nxt = (idx_r == dir_idx_t'(NUM_DIRS - 1)) ? DS_IDLE : DS_DOT;
      default: phase_nxt = DS_IDLE;
    endcase
  end

  always_comb begin
    mul_a = d_r[LW-1:0];
    mul_b = d_r[LW-1:0];
    sh    = '0;
    case (phase_r)
      DS_SQ1: begin
        mul_b = LW'(d_r >> LW);
        sh    = SHW'(LW + 1);
      end
      DS_SQ2: begin
        mul_a = LW'(d_r >> LW);
        mul_b = LW'(d_r >> LW);
        sh    = SHW'(2 * LW);
      end
      default: ;
    endcase
    prod    = mul_a * mul_b;
    acc_nxt = ((phase_r == DS_SQ0) ? '0 : acc_r) + (SQW'(prod) << sh);
    lhs     = kmul(acc_r, bk_r);
    rhs     = kmul(bsq_r, k);
    take    = (idx_r == '0) || (lhs > rhs);
    status.done = done_r;
    status.best = best_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= DS_IDLE;
      done_r  <= 1'b0;
      idx_r   <= '0;
      best_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= (phase_r == DS_CMP) && (idx_r == dir_idx_t'(NUM_DIRS - 1));
      case (phase_r)
        DS_IDLE: if (start) idx_r <= '0;
        DS_DOT:  d_r <= absd;
        DS_SQ0, DS_SQ1, DS_SQ2: acc_r <= acc_nxt;
        DS_CMP: begin
          if (take) begin
            best_r <= idx_r;
            bsq_r  <= acc_r;
            bk_r   <= k;
          end
          idx_r <= idx_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/canny_3d_nonmax_suppression.sv
// Top level of the 3-D non-maximum suppression block: counters, sequencer, configuration.
// Depends on cnms_pkg, cnms_store and cnms_dirsel.
//
//   channel | handshake          | payload
//   in      | in_valid/in_ready  | in_sample, in_first_voxel
//   out     | out_valid/out_ready| out_pos_x/y/z, out_edge_res, out_last_voxel
//   cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A voxel with no decided neighbor leaves the sequencer idle. A voxel that decides an interior voxel
// passes, up to the next transaction, through seven reads of the single-port plane store,
// three gradient steps on one multiplier, a pass over each direction in the shared squarer,
// the neighbor states NB0, NB1 and NB2 and the output state. A zero gradient skips the search.
// Reset is synchronous and needs no clearing pass. A stalled result waits in the output
// register while the next voxel enters.
module canny_3d_nonmax_suppression
  import cnms_pkg::*;
#(
  parameter int MAX_X = DEF_MAX_X,
  parameter int MAX_Y = DEF_MAX_Y,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_sample,
  input  logic        in_first_voxel,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_pos_x,
  output logic [7:0]  out_pos_y,
  output logic [15:0] out_pos_z,
  output logic        out_edge_res,
  output logic        out_last_voxel,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  cfg_idx_t    cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int SB    = SAMPLE_BITS;
  localparam int XCW   = $clog2(MAX_X);
  localparam int YCW   = $clog2(MAX_Y);
  localparam int LXW   = $clog2(MAX_X + 1);
  localparam int LYW   = $clog2(MAX_Y + 1);
  localparam int AW    = XCW + YCW + 2;
  localparam int DEPTH = 3 << (XCW + YCW);
  localparam int GW    = SB + 18;

  logic [8:0]  size_x_r, size_y_r;
  logic [15:0] size_z_r, thr_r, inv_x_r, inv_y_r, inv_z_r;
  logic [LXW-1:0] lat_x_r, lat_x_nxt;
  logic [LYW-1:0] lat_y_r, lat_y_nxt;
  logic [15:0]    lat_z_r, lat_z_nxt;
  logic [XCW-1:0] x_cnt_r, x_cnt_nxt, x_c;
  logic [YCW-1:0] y_cnt_r, y_cnt_nxt, y_c;
  logic [15:0]    z_cnt_r, z_cnt_nxt, z_c;
  logic [1:0]     zm3_r, zm3_nxt, zm3_c;

  logic [XCW-1:0] cur_x_r;
  logic [YCW-1:0] cur_y_r;
  logic [15:0]    cur_z_r;
  logic [1:0]     cur_zm3_r;
  logic           last_r;

  seq_state_t state_r, state_nxt;
  logic [2:0] cnt_r;
  logic [SB-1:0] win_r [7];
  logic signed [GW-1:0] g_r [3];
  logic [SB-1:0] v0_r;
  logic          edge_r;

  logic [7:0]  pos_x_r, pos_y_r;
  logic [15:0] pos_z_r;
  logic        out_edge_r, out_last_r, out_valid_r;

  logic accept, interior, at_origin, gzero, out_load, edge_c;
  logic [47:0] sample_ext;
  logic [SB-1:0] sample_c, mem_rdata;
  logic mem_we, mem_re, ds_start;
  logic [AW-1:0] mem_addr;
  dir_t off;
  logic [XCW-1:0] nx;
  logic [YCW-1:0] ny;
  logic [1:0] np;
  logic signed [SB:0] diff;
  logic [15:0] inv_sel;
  logic signed [GW-1:0] gprod;
  ds_status_t ds_status;
  dir_t bdir;
  logic [31:0] px_m1, py_m1;

  assign accept     = in_valid && in_ready;
  assign cfg_ready  = 1'b1;
  assign sample_ext = {32'b0, in_sample};
  assign sample_c   = sample_ext[SB-1:0];

  // Position counters and size latching.
  always_comb begin
    x_c   = in_first_voxel ? '0 : x_cnt_r;
    y_c   = in_first_voxel ? '0 : y_cnt_r;
    z_c   = in_first_voxel ? '0 : z_cnt_r;
    zm3_c = in_first_voxel ? '0 : zm3_r;
    at_origin = (x_c == '0) && (y_c == '0) && (z_c == '0);
    lat_x_nxt = lat_x_r;
    lat_y_nxt = lat_y_r;
    lat_z_nxt = lat_z_r;
    if (at_origin) begin
      lat_x_nxt = (size_x_r < 9'd3) ? LXW'(3) :
                  (32'(size_x_r) > 32'(MAX_X)) ? LXW'(MAX_X) : LXW'(size_x_r);
      lat_y_nxt = (size_y_r < 9'd3) ? LYW'(3) :
                  (32'(size_y_r) > 32'(MAX_Y)) ? LYW'(MAX_Y) : LYW'(size_y_r);
      lat_z_nxt = (size_z_r < 16'd3) ? 16'd3 : size_z_r;
    end
    interior  = (x_c >= XCW'(2)) && (y_c >= YCW'(2)) && (z_c >= 16'd2);
    x_cnt_nxt = x_c + 1'b1;
    y_cnt_nxt = y_c;
    z_cnt_nxt = z_c;
    zm3_nxt   = zm3_c;
    if (LXW'(x_c) + 1'b1 >= lat_x_nxt) begin
      x_cnt_nxt = '0;
      y_cnt_nxt = y_c + 1'b1;
      if (LYW'(y_c) + 1'b1 >= lat_y_nxt) begin
        y_cnt_nxt = '0;
        z_cnt_nxt = z_c + 1'b1;
        zm3_nxt   = mod3({1'b0, zm3_c} + 3'd1);
        if (17'(z_c) + 1'b1 >= 17'(lat_z_nxt)) begin
          z_cnt_nxt = '0;
          zm3_nxt   = '0;
        end
      end
    end
  end

  always_comb begin
    case (cnt_r)
      3'd0:    diff = $signed({1'b0, win_r[2]}) - $signed({1'b0, win_r[1]});
      3'd1:    diff = $signed({1'b0, win_r[4]}) - $signed({1'b0, win_r[3]});
      default: diff = $signed({1'b0, win_r[6]}) - $signed({1'b0, win_r[5]});
    endcase
    case (cnt_r)
      3'd0:    inv_sel = inv_x_r;
      3'd1:    inv_sel = inv_y_r;
      default: inv_sel = inv_z_r;
    endcase
    gprod  = GW'(diff) * GW'($signed({1'b0, inv_sel}));
    gzero  = (g_r[0] == '0) && (g_r[1] == '0) && (gprod == '0);
    bdir   = dir_vec(ds_status.best);
    edge_c = (win_r[0] > v0_r) && (win_r[0] > mem_rdata) && (32'(win_r[0]) >= 32'(thr_r));
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (accept && interior) state_nxt = ST_READ;
      ST_READ:   if (cnt_r == 3'd7) state_nxt = ST_GRAD;
      ST_GRAD:   if (cnt_r == 3'd2) state_nxt = gzero ? ST_OUT : ST_SEARCH;
      ST_SEARCH: if (ds_status.done) state_nxt = ST_NB0;
      ST_NB0:    state_nxt = ST_NB1;
      ST_NB1:    state_nxt = ST_NB2;
      ST_NB2:    state_nxt = ST_OUT;
      ST_OUT:    if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state_r == ST_IDLE);
    ds_start = (state_r == ST_GRAD) && (cnt_r == 3'd2) && !gzero;
    out_load = (state_r == ST_OUT) && (!out_valid_r || out_ready);
    mem_we   = accept;
    mem_re   = ((state_r == ST_READ) && (cnt_r != 3'd7)) ||
               (state_r == ST_NB0) || (state_r == ST_NB1);
    off = '{DZ, DZ, DZ};
    case (state_r)
      ST_READ: begin
        case (cnt_r)
          3'd1:    off.dx = DN;
          3'd2:    off.dx = DP;
          3'd3:    off.dy = DN;
          3'd4:    off.dy = DP;
          3'd5:    off.dz = DN;
          3'd6:    off.dz = DP;
          default: ;
        endcase
      end
      ST_NB0:  off = bdir;
      ST_NB1:  off = '{-bdir.dx, -bdir.dy, -bdir.dz};
      default: ;
    endcase
    nx = cur_x_r + {{(XCW-2){off.dx[1]}}, off.dx} - XCW'(1);
    ny = cur_y_r + {{(YCW-2){off.dy[1]}}, off.dy} - YCW'(1);
    np = mod3({1'b0, cur_zm3_r} + 3'd2 + {off.dz[1], off.dz});
    mem_addr = mem_we ? {zm3_c, y_c, x_c} : {np, ny, nx};
  end

  cnms_store #(.AW(AW), .DEPTH(DEPTH), .DW(SB)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (sample_c),
    .rdata (mem_rdata)
  );

  cnms_dirsel #(.GW(GW)) u_dirsel (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (ds_start),
    .gx     (g_r[0]),
    .gy     (g_r[1]),
    .gz     (g_r[2]),
    .status (ds_status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= 9'd256;
      size_y_r <= 9'd256;
      size_z_r <= 16'd256;
      thr_r    <= 16'd9830;
      inv_x_r  <= 16'd256;
      inv_y_r  <= 16'd256;
      inv_z_r  <= 16'd256;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SIZE_X:    size_x_r <= cfg_data[8:0];
        CFG_SIZE_Y:    size_y_r <= cfg_data[8:0];
        CFG_SIZE_Z:    size_z_r <= cfg_data;
        CFG_THRESHOLD: thr_r    <= cfg_data;
        CFG_INV_X:     inv_x_r  <= cfg_data;
        CFG_INV_Y:     inv_y_r  <= cfg_data;
        CFG_INV_Z:     inv_z_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      x_cnt_r     <= '0;
      y_cnt_r     <= '0;
      z_cnt_r     <= '0;
      zm3_r       <= '0;
      lat_x_r     <= LXW'(MAX_X < 256 ? MAX_X : 256);
      lat_y_r     <= LYW'(MAX_Y < 256 ? MAX_Y : 256);
      lat_z_r     <= 16'd256;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= (state_nxt != state_r) ? 3'd0 : cnt_r + 1'b1;
      if (accept) begin
        x_cnt_r <= x_cnt_nxt;
        y_cnt_r <= y_cnt_nxt;
        z_cnt_r <= z_cnt_nxt;
        zm3_r   <= zm3_nxt;
        lat_x_r <= lat_x_nxt;
        lat_y_r <= lat_y_nxt;
        lat_z_r <= lat_z_nxt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign px_m1 = 32'(cur_x_r) - 32'd1;
  assign py_m1 = 32'(cur_y_r) - 32'd1;

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_x_r   <= x_c;
      cur_y_r   <= y_c;
      cur_z_r   <= z_c;
      cur_zm3_r <= zm3_c;
      last_r    <= (LXW'(x_c) == lat_x_nxt - 1'b1) && (LYW'(y_c) == lat_y_nxt - 1'b1) &&
                   (z_c == lat_z_nxt - 16'd1);
    end
    if ((state_r == ST_READ) && (cnt_r != 3'd0)) begin
      win_r[cnt_r - 3'd1] <= mem_rdata;
    end
    if (state_r == ST_GRAD) begin
      g_r[cnt_r[1:0]] <= gprod;
      if (cnt_r == 3'd2) begin
        edge_r <= 1'b0;
      end
    end
    if (state_r == ST_NB1) begin
      v0_r <= mem_rdata;
    end
    if (state_r == ST_NB2) begin
      edge_r <= edge_c;
    end
    if (out_load) begin
      pos_x_r    <= px_m1[7:0];
      pos_y_r    <= py_m1[7:0];
      pos_z_r    <= cur_z_r - 16'd1;
      out_edge_r <= edge_r;
      out_last_r <= last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pos_x      = pos_x_r;
  assign out_pos_y      = pos_y_r;
  assign out_pos_z      = pos_z_r;
  assign out_edge_res   = out_edge_r;
  assign out_last_voxel = out_last_r;

endmodule

FILE: rtl/cnms_checker.sv
// Port-level checker for the 3-D non-maximum suppression block, bound to the top level.
// Depends on cnms_pkg for the configuration index type.
module cnms_checker
  import cnms_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [15:0] in_sample,
  input logic        in_first_voxel,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_pos_x,
  input logic [7:0]  out_pos_y,
  input logic [15:0] out_pos_z,
  input logic        out_edge_res,
  input logic        out_last_voxel,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input cfg_idx_t    cfg_index,
  input logic [15:0] cfg_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_pos_z) && $stable(out_edge_res))
    else $error("stalled result payload changed");

  a_no_fast_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result appeared one cycle after an input transaction");

  a_interior: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pos_z != 16'd0) && (out_pos_y != 8'd0) && (out_pos_x != 8'd0))
    else $error("result position is on the volume border");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind canny_3d_nonmax_suppression cnms_checker u_cnms_checker (.*);
